// ===== rtl/psp_pkg.sv =====
// Shared types, constants and codes for the polyphonic sample player.
package psp_pkg;

    localparam int VOICE_COUNT     = 8;
    localparam int FRAME_ADDR_BITS = 16;

    localparam int VOICE_BITS  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int STORE_DEPTH = 1 << FRAME_ADDR_BITS;
    localparam int LEN_W       = (FRAME_ADDR_BITS + 1 > 17) ? FRAME_ADDR_BITS + 1 : 17;
    localparam int CMP_W       = (LEN_W > 24) ? LEN_W : 24;
    localparam int POS_W       = 40;
    localparam int LEVEL_W     = 16;
    localparam int VOICE_W     = POS_W + LEVEL_W;
    localparam int FRAME_W     = 32;
    localparam int ACC_W       = 32;
    localparam int CNT_W       = 7;
    localparam int CNT_MAX     = 15;
    localparam int ACT_MAX     = (VOICE_COUNT < CNT_MAX) ? VOICE_COUNT : CNT_MAX;
    localparam int OUT_W       = 24;

    // Configuration register indexes
    localparam logic [1:0] CFG_RATE_STEP     = 2'd0;
    localparam logic [1:0] CFG_MASTER_GAIN   = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_LENGTH = 2'd2;
    localparam logic [1:0] CFG_SOURCE_STEREO = 2'd3;

    // Reset values of the configuration registers
    localparam logic [23:0] RATE_STEP_RST     = 24'd65536;
    localparam logic [15:0] MASTER_GAIN_RST   = 16'd32768;
    localparam logic [16:0] SAMPLE_LENGTH_RST = 17'd0;
    localparam logic        SOURCE_STEREO_RST = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_NOTE   = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VREAD,
        S_VEVAL,
        S_F0,
        S_F1,
        S_MUL,
        S_ADD,
        S_SCALE,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic [15:0]        load_address;
        logic signed [15:0] load_left;
        logic signed [15:0] load_right;
        logic [15:0]        note_gain;
    } t_in;

    typedef struct packed {
        logic signed [23:0] out_left;
        logic signed [23:0] out_right;
        logic [3:0]         active_count;
    } t_out;

    // Step strobes from the sequencer to the mixing datapath
    typedef struct packed {
        logic clear;
        logic load_g;
        logic load_f0;
        logic load_f1;
        logic mul;
        logic add;
        logic scale;
        logic acc;
    } t_mix_ctl;

endpackage

// ===== rtl/psp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module psp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/psp_mix.sv =====
// Per-voice interpolation, gain scaling and stereo accumulation datapath.
module psp_mix import psp_pkg::*; (
    input  logic                     i_clk,
    input  t_mix_ctl                 i_ctl,
    input  logic [FRAME_W-1:0]       i_frame,
    input  logic [15:0]              i_frac,
    input  logic [LEVEL_W-1:0]       i_level,
    input  logic [15:0]              i_master,
    input  logic                     i_stereo,
    output logic signed [OUT_W-1:0]  o_left,
    output logic signed [OUT_W-1:0]  o_right
);

    logic [15:0]             r_frac;
    logic [31:0]             r_g;
    logic [FRAME_W-1:0]      r_f0;
    logic [FRAME_W-1:0]      r_f1;
    logic signed [33:0]      r_pl;
    logic signed [33:0]      r_pr;
    logic signed [15:0]      r_l;
    logic signed [15:0]      r_r;
    logic signed [48:0]      r_cl;
    logic signed [48:0]      r_cr;
    logic signed [ACC_W-1:0] r_sum_l;
    logic signed [ACC_W-1:0] r_sum_r;

    logic signed [16:0] dl;
    logic signed [16:0] dr;
    logic signed [16:0] frac_s;
    logic signed [17:0] il;
    logic signed [17:0] ir;
    logic signed [32:0] g_s;
    logic signed [48:0] sh_l;
    logic signed [48:0] sh_r;

    // Differences, interpolated values and shifted contributions
    always_comb begin
        frac_s = $signed({1'b0, r_frac});
        dl     = 17'($signed(r_f1[15:0])) - 17'($signed(r_f0[15:0]));
        dr     = 17'($signed(r_f1[31:16])) - 17'($signed(r_f0[31:16]));
        il     = 18'($signed(r_f0[15:0])) + 18'(r_pl >>> 16);
        ir     = 18'($signed(r_f0[31:16])) + 18'(r_pr >>> 16);
        g_s    = $signed({1'b0, r_g});
        sh_l   = r_cl >>> 22;
        sh_r   = r_cr >>> 22;
    end

    // Advance one step per strobe
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_g) begin
            r_frac <= i_frac;
            r_g    <= 32'(i_level) * 32'(i_master);
        end
        if (i_ctl.load_f0) begin
            r_f0 <= i_frame;
        end
        if (i_ctl.load_f1) begin
            r_f1 <= i_frame;
        end
        if (i_ctl.mul) begin
            r_pl <= frac_s * dl;
            r_pr <= frac_s * dr;
        end
        if (i_ctl.add) begin
            r_l <= il[15:0];
            r_r <= i_stereo ? ir[15:0] : il[15:0];
        end
        if (i_ctl.scale) begin
            r_cl <= r_l * g_s;
            r_cr <= r_r * g_s;
        end
        if (i_ctl.clear) begin
            r_sum_l <= '0;
            r_sum_r <= '0;
        end else if (i_ctl.acc) begin
            r_sum_l <= r_sum_l + $signed(sh_l[ACC_W-1:0]);
            r_sum_r <= r_sum_r + $signed(sh_r[ACC_W-1:0]);
        end
    end

    // Saturate the sums to the output range
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(1 << (OUT_W - 1));

    always_comb begin
        if (r_sum_l > SAT_MAX) begin
            o_left = SAT_MAX[OUT_W-1:0];
        end else if (r_sum_l < SAT_MIN) begin
            o_left = SAT_MIN[OUT_W-1:0];
        end else begin
            o_left = r_sum_l[OUT_W-1:0];
        end
        if (r_sum_r > SAT_MAX) begin
            o_right = SAT_MAX[OUT_W-1:0];
        end else if (r_sum_r < SAT_MIN) begin
            o_right = SAT_MIN[OUT_W-1:0];
        end else begin
            o_right = r_sum_r[OUT_W-1:0];
        end
    end

endmodule

// ===== rtl/polyphonic_sample_player.sv =====
// Polyphonic one-shot sample player: load, note-on and tick items over voice and frame RAMs.
// Load and note-on beats give no result.
// A tick reads and evaluates each voice in turn and, for a sounding voice, fetches two
// frames, then multiplies, adds, scales and accumulates; with no sample loaded it ends at once.
// The result sits in an output register, so the next beat is taken while it waits.
// Synchronous active-low reset clears all voices and loads the register defaults;
// the frame RAM is not cleared.
module polyphonic_sample_player import psp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [23:0]              r_rate_step;
    logic [15:0]              r_master_gain;
    logic [16:0]              r_sample_length;
    logic                     r_source_stereo;

    logic [VOICE_COUNT-1:0]     r_busy, n_busy;
    logic [VOICE_BITS-1:0]      r_voice, n_voice;
    logic [FRAME_ADDR_BITS-1:0] r_addr1, n_addr1;
    logic                       r_out_valid, n_out_valid;
    t_out                       r_out, n_out;

    logic                       in_take;
    logic                       out_take;
    logic [LEN_W-1:0]           len_ext;
    logic [LEN_W-1:0]           len;
    logic [CMP_W-1:0]           lim;
    logic [POS_W-1:0]           pos;
    logic [LEVEL_W-1:0]         level;
    logic                       at_end;
    logic                       last_voice;
    logic [VOICE_BITS-1:0]      pick;
    logic [CNT_W-1:0]           busy_cnt;

    logic                       frame_we;
    logic [FRAME_ADDR_BITS-1:0] frame_waddr;
    logic [FRAME_W-1:0]         frame_wdata;
    logic [FRAME_ADDR_BITS-1:0] frame_raddr;
    logic [FRAME_W-1:0]         frame_rdata;

    logic                       voice_we;
    logic [VOICE_BITS-1:0]      voice_waddr;
    logic [VOICE_W-1:0]         voice_wdata;
    logic [VOICE_W-1:0]         voice_rdata;

    t_mix_ctl                   mix_ctl;
    logic signed [OUT_W-1:0]    mix_left;
    logic signed [OUT_W-1:0]    mix_right;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_step     <= RATE_STEP_RST;
            r_master_gain   <= MASTER_GAIN_RST;
            r_sample_length <= SAMPLE_LENGTH_RST;
            r_source_stereo <= SOURCE_STEREO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RATE_STEP:     r_rate_step     <= i_cfg_data;
                CFG_MASTER_GAIN:   r_master_gain   <= i_cfg_data[15:0];
                CFG_SAMPLE_LENGTH: r_sample_length <= i_cfg_data[16:0];
                CFG_SOURCE_STEREO: r_source_stereo <= i_cfg_data[0];
            endcase
        end
    end

    // Frame store
    psp_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (frame_we),
        .i_waddr (frame_waddr),
        .i_wdata (frame_wdata),
        .i_raddr (frame_raddr),
        .o_rdata (frame_rdata)
    );

    // Voice position and level store
    psp_ram #(
        .WIDTH (VOICE_W),
        .DEPTH (VOICE_COUNT)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (voice_we),
        .i_waddr (voice_waddr),
        .i_wdata (voice_wdata),
        .i_raddr (r_voice),
        .o_rdata (voice_rdata)
    );

    psp_mix u_mix (
        .i_clk    (i_clk),
        .i_ctl    (mix_ctl),
        .i_frame  (frame_rdata),
        .i_frac   (pos[15:0]),
        .i_level  (level),
        .i_master (r_master_gain),
        .i_stereo (r_source_stereo),
        .o_left   (mix_left),
        .o_right  (mix_right)
    );

    // Clamp the length and decode the voice read back
    always_comb begin
        len_ext    = LEN_W'(r_sample_length);
        len        = (len_ext > LEN_W'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH) : len_ext;
        lim        = CMP_W'(len) - CMP_W'(1);
        pos        = voice_rdata[VOICE_W-1:LEVEL_W];
        level      = voice_rdata[LEVEL_W-1:0];
        at_end     = CMP_W'(pos[POS_W-1:16]) >= lim;
        last_voice = r_voice == VOICE_BITS'(VOICE_COUNT - 1);
        busy_cnt   = CNT_W'($countones(r_busy));
    end

    // First idle voice, voice 0 when all are busy
    always_comb begin
        pick = '0;
        for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
            if (!r_busy[v]) begin
                pick = VOICE_BITS'(v);
            end
        end
    end

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;

    // Sequencer: next state, RAM controls and datapath strobes
    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_voice     = r_voice;
        n_addr1     = r_addr1;
        n_out_valid = out_take ? 1'b0 : r_out_valid;
        n_out       = r_out;
        frame_we    = 1'b0;
        frame_waddr = FRAME_ADDR_BITS'(i_in.load_address);
        frame_wdata = {i_in.load_right, i_in.load_left};
        frame_raddr = r_addr1;
        voice_we    = 1'b0;
        voice_waddr = r_voice;
        voice_wdata = {pos + POS_W'(r_rate_step), level};
        mix_ctl     = '0;
        o_in_stall  = r_state != S_IDLE;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in.command)
                        CMD_LOAD: begin
                            frame_we = 1'b1;
                            n_busy   = '0;
                        end
                        CMD_NOTE: begin
                            voice_we      = 1'b1;
                            voice_waddr   = pick;
                            voice_wdata   = {POS_W'(0), i_in.note_gain};
                            n_busy[pick]  = 1'b1;
                        end
                        CMD_TICK: begin
                            mix_ctl.clear = 1'b1;
                            n_voice       = '0;
                            n_state       = (len == '0) ? S_DONE : S_VREAD;
                        end
                        CMD_UNUSED: begin
                            // drop the beat
                        end
                    endcase
                end
            end
            S_VREAD: begin
                n_state = S_VEVAL;
            end
            S_VEVAL: begin
                if (r_busy[r_voice] && !at_end) begin
                    frame_raddr    = pos[16 +: FRAME_ADDR_BITS];
                    n_addr1        = pos[16 +: FRAME_ADDR_BITS] + FRAME_ADDR_BITS'(1);
                    voice_we       = 1'b1;
                    mix_ctl.load_g = 1'b1;
                    n_state        = S_F0;
                end else begin
                    n_busy[r_voice] = 1'b0;
                    n_voice         = r_voice + VOICE_BITS'(1);
                    n_state         = last_voice ? S_DONE : S_VREAD;
                end
            end
            S_F0: begin
                mix_ctl.load_f0 = 1'b1;
                n_state         = S_F1;
            end
            S_F1: begin
                mix_ctl.load_f1 = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                mix_ctl.mul = 1'b1;
                n_state     = S_ADD;
            end
            S_ADD: begin
                mix_ctl.add = 1'b1;
                n_state     = S_SCALE;
            end
            S_SCALE: begin
                mix_ctl.scale = 1'b1;
                n_state       = S_ACC;
            end
            S_ACC: begin
                mix_ctl.acc = 1'b1;
                n_voice     = r_voice + VOICE_BITS'(1);
                n_state     = last_voice ? S_DONE : S_VREAD;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || out_take) begin
                    n_out.out_left     = mix_left;
                    n_out.out_right    = mix_right;
                    n_out.active_count = (busy_cnt > CNT_W'(CNT_MAX)) ?
                                         4'(CNT_MAX) : busy_cnt[3:0];
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (!in_take && r_state == S_IDLE) begin
            frame_we = 1'b0;
            voice_we = 1'b0;
            mix_ctl  = '0;
            n_busy   = r_busy;
            n_state  = S_IDLE;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_voice     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_voice     <= n_voice;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr1 <= n_addr1;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Frame store is written only between items
    a_frame_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_we |-> (r_state == S_IDLE))
        else $error("frame store written during a tick");

    // Voice store is written only by a note-on or a voice update
    a_voice_we_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        voice_we |-> (r_state == S_IDLE || r_state == S_VEVAL))
        else $error("voice store written outside note-on or update");

    // A new result only follows the end of a tick
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished tick");

    // No voice is claimed during a tick
    a_tick_no_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> ($countones(r_busy) <= $past($countones(r_busy))))
        else $error("voice claimed during a tick");

    // Reported count stays within the voice count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.active_count <= 4'(ACT_MAX)))
        else $error("active count out of range");

endmodule

// ===== verif/polyphonic_sample_player_tb.sv =====
// Self-checking testbench for the polyphonic sample player: directed and random beats.
module polyphonic_sample_player_tb import psp_pkg::*;;

    localparam int TARGET_ITEMS = 700;
    localparam int TAIL_CYCLES  = 100;
    localparam int HOLD_CYCLES  = 800;
    localparam int RUN_LIMIT    = 5_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    polyphonic_sample_player dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Mirror of the block: frame store, voices and registers
    logic [31:0]  frame_mem     [STORE_DEPTH];
    bit           frame_written [STORE_DEPTH];
    bit           voice_on      [VOICE_COUNT];
    logic [39:0]  voice_pos     [VOICE_COUNT];
    logic [15:0]  voice_lvl     [VOICE_COUNT];
    logic [23:0]  cfg_rate   = RATE_STEP_RST;
    logic [15:0]  cfg_gain   = MASTER_GAIN_RST;
    logic [16:0]  cfg_len    = SAMPLE_LENGTH_RST;
    bit           cfg_stereo = SOURCE_STEREO_RST;

    t_out pending_mix [$];
    int   errors     = 0;
    int   items_sent = 0;
    int   out_beats  = 0;
    bit   calm       = 1'b0;
    bit   out_hold   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("polyphonic_sample_player: mismatch");
        $finish;
    end

    // Linear step between two frames, floor on the fraction product
    function automatic longint lerp(input longint a, input longint b, input longint frac);
        return a + ((frac * (b - a)) >>> 16);
    endfunction

    function automatic logic [23:0] sat24(input longint v);
        if (v > 64'sd8388607) return 24'h7FFFFF;
        if (v < -64'sd8388608) return 24'h800000;
        return v[23:0];
    endfunction

    function automatic longint clamped_len();
        return (cfg_len > STORE_DEPTH) ? longint'(STORE_DEPTH) : longint'(cfg_len);
    endfunction

    // Apply one beat to the mirror; return 1 with the mixed frame for a tick
    function automatic bit advance_voices(input t_in it, output t_out mix);
        longint      sum_l, sum_r, l, r, g, len;
        logic [23:0] idx;
        logic [31:0] f0, f1;
        int          pick, count;
        mix = '0;
        case (it.command)
            CMD_LOAD: begin
                frame_mem[it.load_address]     = {it.load_right, it.load_left};
                frame_written[it.load_address] = 1'b1;
                for (int v = 0; v < VOICE_COUNT; v++) voice_on[v] = 1'b0;
                return 1'b0;
            end
            CMD_NOTE: begin
                pick = 0;
                for (int v = VOICE_COUNT - 1; v >= 0; v--) if (!voice_on[v]) pick = v;
                voice_on[pick]  = 1'b1;
                voice_pos[pick] = '0;
                voice_lvl[pick] = it.note_gain;
                return 1'b0;
            end
            CMD_TICK: begin
                sum_l = 0;
                sum_r = 0;
                len   = clamped_len();
                if (len != 0) begin
                    for (int v = 0; v < VOICE_COUNT; v++) begin
                        if (voice_on[v]) begin
                            idx = voice_pos[v][39:16];
                            if (longint'(idx) >= len - 1) begin
                                voice_on[v] = 1'b0;
                            end else begin
                                f0 = frame_mem[int'(idx)];
                                f1 = frame_mem[int'(idx) + 1];
                                l  = lerp(longint'($signed(f0[15:0])), longint'($signed(f1[15:0])),
                                          longint'(voice_pos[v][15:0]));
                                r  = cfg_stereo ?
                                     lerp(longint'($signed(f0[31:16])),
                                          longint'($signed(f1[31:16])),
                                          longint'(voice_pos[v][15:0])) : l;
                                g  = longint'(voice_lvl[v]) * longint'(cfg_gain);
                                sum_l += (l * g) >>> 22;
                                sum_r += (r * g) >>> 22;
                                voice_pos[v] = voice_pos[v] + {16'd0, cfg_rate};
                            end
                        end
                    end
                end
                count = 0;
                for (int v = 0; v < VOICE_COUNT; v++) if (voice_on[v]) count++;
                if (count > CNT_MAX) count = CNT_MAX;
                mix.out_left     = sat24(sum_l);
                mix.out_right    = sat24(sum_r);
                mix.active_count = count[3:0];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // First frame a tick would read before it was ever loaded, or -1
    function automatic int missing_frame();
        longint      len;
        logic [23:0] idx;
        len = clamped_len();
        if (len == 0) return -1;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            idx = voice_pos[v][39:16];
            if (voice_on[v] && longint'(idx) < len - 1) begin
                if (!frame_written[int'(idx)]) return int'(idx);
                if (!frame_written[int'(idx) + 1]) return int'(idx) + 1;
            end
        end
        return -1;
    endfunction

    function automatic t_in make_item(input t_cmd c);
        t_in it;
        it.command      = c;
        it.load_address = 16'($urandom);
        it.load_left    = 16'($urandom);
        it.load_right   = 16'($urandom);
        it.note_gain    = 16'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return 16'd32768;
            1:       return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic t_in load_item(input int addr, input logic [15:0] l,
                                      input logic [15:0] r);
        t_in it;
        it              = make_item(CMD_LOAD);
        it.load_address = addr[15:0];
        it.load_left    = l;
        it.load_right   = r;
        return it;
    endfunction

    function automatic t_in note_item(input logic [15:0] lvl);
        t_in it;
        it           = make_item(CMD_NOTE);
        it.note_gain = lvl;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("output beat %0d: %s got %0d, expected %0d", out_beats, what, got, want);
    endtask

    // Offer one beat after a random gap; hold it until taken, then predict
    task automatic send_beat(input t_in it);
        int   gap;
        t_out mix;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (advance_voices(it, mix)) pending_mix.push_back(mix);
        if (it.command != CMD_UNUSED) items_sent++;
    endtask

    // Tick, or first load the frame a sounding voice would read unwritten
    task automatic send_tick();
        int miss;
        miss = missing_frame();
        if (miss >= 0) send_beat(load_item(miss, pick_sample(), pick_sample()));
        else send_beat(make_item(CMD_TICK));
    endtask

    // Hold the input until every expected frame is out, then let the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_mix.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_apply(input logic [23:0] rate, input logic [15:0] gain,
                             input logic [16:0] len, input bit stereo);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_RATE_STEP;
        i_cfg_data  <= rate;
        @(posedge i_clk);
        i_cfg_index <= CFG_MASTER_GAIN;
        i_cfg_data  <= {8'd0, gain};
        @(posedge i_clk);
        i_cfg_index <= CFG_SAMPLE_LENGTH;
        i_cfg_data  <= {7'd0, len};
        @(posedge i_clk);
        i_cfg_index <= CFG_SOURCE_STEREO;
        i_cfg_data  <= {23'd0, stereo};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_rate   = rate;
        cfg_gain   = gain;
        cfg_len    = len;
        cfg_stereo = stereo;
    endtask

    // Reset values: no sample loaded, so ticks stay silent and voices do not move
    task automatic test_no_sample();
        send_beat(note_item(16'd32768));
        send_beat(make_item(CMD_UNUSED));
        send_tick();
        send_tick();
    endtask

    // Fractional rate across extreme frames, two voices, top address loaded
    task automatic test_interpolation();
        cfg_apply(24'd49152, 16'd32768, 17'd3, 1'b1);
        send_beat(load_item(0, 16'h7FFF, 16'h8000));
        send_beat(load_item(1, 16'h8000, 16'h7FFF));
        send_beat(load_item(2, 16'h0000, 16'h0000));
        send_beat(load_item(16'hFFFF, 16'h8000, 16'h7FFF));
        send_beat(note_item(16'd32768));
        send_beat(note_item(16'd16384));
        repeat (4) send_tick();
    endtask

    // A high master gain and full levels drive both rails into saturation
    task automatic test_saturation();
        cfg_apply(24'd65536, 16'd49152, 17'd3, 1'b1);
        send_beat(note_item(16'd32768));
        send_beat(note_item(16'hFFFF));
        repeat (2) send_tick();
    endtask

    // One frame only: every voice stops at its first tick
    task automatic test_single_frame();
        cfg_apply(24'd65536, 16'd32768, 17'd1, 1'b0);
        send_beat(note_item(16'd32768));
        repeat (2) send_tick();
    endtask

    // Length above the store depth is clamped; mono source on both outputs
    task automatic test_long_length();
        cfg_apply(24'd32768, 16'd49152, 17'h1FFFF, 1'b0);
        send_beat(note_item(16'd32768));
        repeat (2) send_tick();
    endtask

    // Hold the output for a long stretch while ticks keep coming
    task automatic test_backpressure();
        calm = 1'b1;
        cfg_apply(24'd16384, 16'd32768, 17'd8, 1'b1);
        for (int a = 0; a < 8; a++) send_beat(load_item(a, pick_sample(), pick_sample()));
        repeat (VOICE_COUNT) send_beat(note_item(pick_level()));
        fork
            begin
                out_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_hold = 1'b0;
            end
            repeat (12) send_tick();
        join
        calm = 1'b0;
        drain_results();
    endtask

    // Phases of random settings: load a prefix, then mixed notes, ticks and noise
    task automatic test_random_phases();
        logic [23:0] rate;
        logic [15:0] gain;
        logic [16:0] len;
        int          n_load, n_body, pick;
        while (items_sent < TARGET_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       rate = 24'd65536;
                1:       rate = 24'($urandom_range(1, 65535));
                2:       rate = 24'($urandom_range(65536, 262144));
                3:       rate = 24'd0;
                4:       rate = 24'hFFFFFF;
                5:       rate = 24'($urandom);
                default: rate = 24'($urandom_range(4096, 98304));
            endcase
            case ($urandom_range(0, 3))
                0:       gain = 16'd0;
                1:       gain = 16'd49152;
                default: gain = 16'($urandom_range(0, 49152));
            endcase
            case ($urandom_range(0, 9))
                0:       len = 17'd0;
                1:       len = 17'd1;
                2:       len = 17'd65536;
                3:       len = 17'h1FFFF;
                default: len = 17'($urandom_range(2, 20));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            cfg_apply(rate, gain, len, 1'($urandom_range(0, 1)));
            n_load = (len == 0) ? 2 : ((len > 20) ? 20 : int'(len));
            if ($urandom_range(0, 3) != 0)
                for (int a = 0; a < n_load; a++)
                    send_beat(load_item(a, pick_sample(), pick_sample()));
            n_body = $urandom_range(10, 30);
            for (int k = 0; k < n_body; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) send_tick();
                else if (pick < 82) send_beat(note_item(pick_level()));
                else if (pick < 90) begin
                    if ($urandom_range(0, 1) != 0)
                        send_beat(load_item($urandom_range(0, n_load - 1),
                                            pick_sample(), pick_sample()));
                    else send_beat(make_item(CMD_LOAD));
                end else send_beat(make_item(CMD_UNUSED));
            end
        end
        calm = 1'b0;
    endtask

    // Output stall: random wait per frame, or held high during a hold-off
    initial begin : out_stall_drive
        int gap;
        gap = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) gap = calm ? 0 : $urandom_range(0, 8);
            i_out_stall <= out_hold || (gap > 0);
            if (gap > 0) gap--;
        end
    end

    // Compare each frame taken with the oldest prediction
    initial begin : mix_compare
        t_out want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (pending_mix.size() == 0) begin
                    report_mismatch("beat with nothing expected", 0, 0);
                end else begin
                    want = pending_mix.pop_front();
                    if (o_out.out_left !== want.out_left)
                        report_mismatch("out_left", o_out.out_left, want.out_left);
                    if (o_out.out_right !== want.out_right)
                        report_mismatch("out_right", o_out.out_right, want.out_right);
                    if (o_out.active_count !== want.active_count)
                        report_mismatch("active_count", o_out.active_count,
                                        want.active_count);
                end
                out_beats++;
            end
        end
    end

    initial begin
        for (int v = 0; v < VOICE_COUNT; v++) begin
            voice_on[v]  = 1'b0;
            voice_pos[v] = '0;
            voice_lvl[v] = '0;
        end
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_RATE_STEP;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_sample();
        test_interpolation();
        test_saturation();
        test_single_frame();
        test_long_length();
        test_backpressure();
        test_random_phases();
        drain_results();

        if (errors == 0) $display("polyphonic_sample_player: match");
        else $display("polyphonic_sample_player: mismatch");
        $finish;
    end

endmodule
